// ===== hdl/sdioe_pkg.sv =====
// Shared types, codes and helpers for the SDIO card enumeration sequencer.
`timescale 1ns / 1ps

package sdioe_pkg;

  // Event codes on the op field
  localparam logic [1:0] OP_START     = 2'd0;
  localparam logic [1:0] OP_CMD_DONE  = 2'd1;
  localparam logic [1:0] OP_CLK_DONE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENUM_DIV  = 2'd0;
  localparam logic [1:0] CFG_RUN_DIV   = 2'd1;
  localparam logic [1:0] CFG_QUERY_LIM = 2'd2;
  localparam logic [1:0] CFG_READY_LIM = 2'd3;

  // Configuration reset values
  localparam logic [9:0]  ENUM_DIV_RST  = 10'd63;
  localparam logic [9:0]  RUN_DIV_RST   = 10'd1;
  localparam logic [12:0] QUERY_LIM_RST = 13'd5000;
  localparam logic [7:0]  READY_LIM_RST = 8'd100;

  // OCR voltage window and IORDY bit
  localparam logic [31:0] VOLT_WINDOW = 32'h00FF_FF80;
  localparam int          IORDY_POS   = 31;

  // SD command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_IO_SEND   = 6'd5;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_SELECT    = 6'd7;

  // Response kinds
  localparam logic [1:0] RSP_NONE   = 2'd0;
  localparam logic [1:0] RSP_LONG   = 2'd1;
  localparam logic [1:0] RSP_SHORT  = 2'd2;
  localparam logic [1:0] RSP_BUSY   = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CLK_ENUM = 4'd1,
    PH_CMD0     = 4'd2,
    PH_QUERY    = 4'd3,
    PH_READY    = 4'd4,
    PH_CMD3     = 4'd5,
    PH_CMD7     = 4'd6,
    PH_CLK_RUN  = 4'd7,
    PH_DONE     = 4'd8,
    PH_FAILED   = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ACT_WAIT  = 3'd0,
    ACT_ISSUE = 3'd1,
    ACT_CLOCK = 3'd2,
    ACT_OK    = 3'd3,
    ACT_FAIL  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_TIMEOUT = 3'd1,
    ERR_CRC     = 3'd2,
    ERR_CMD     = 3'd3,
    ERR_DATA    = 3'd4,
    ERR_ENUM    = 3'd5
  } err_t;

  // One input event
  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  error_flags;
    logic        wait_expired;
    logic [31:0] response_word;
  } item_t;

  // One result beat
  typedef struct packed {
    action_t     action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [1:0]  response_kind;
    logic        check_enable;
    logic [9:0]  clock_divisor;
    err_t        error_code;
    logic [31:0] card_ocr;
    logic [15:0] card_address;
  } result_t;

  // Classify raw flags when bit 6 is set: timeout, then crc, then command, data as fallback; else timeout if expired
  function automatic err_t outcome(input logic [6:0] flags, input logic expired);
    err_t e;
    if (flags[6]) begin
      if (|flags[1:0])      e = ERR_TIMEOUT;
      else if (|flags[3:2]) e = ERR_CRC;
      else if (|flags[5:4]) e = ERR_CMD;
      else                  e = ERR_DATA;
    end else begin
      e = expired ? ERR_TIMEOUT : ERR_OK;
    end
    return e;
  endfunction

endpackage

// ===== hdl/sdioe_in_reg.sv =====
// Input register stage: holds one accepted event until the step logic takes it.
`timescale 1ns / 1ps

module sdioe_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            advance,
  input  sdioe_pkg::item_t item_d,
  output sdioe_pkg::item_t item_q,
  output logic            item_valid
);

  // Valid flag: set on an accepted beat, cleared when the stage drains
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hdl/sdioe_step.sv =====
// Sequencer step: config registers, bring-up state and next-result logic.
`timescale 1ns / 1ps

module sdioe_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic              fire,
  input  sdioe_pkg::item_t  item,
  output sdioe_pkg::result_t res
);

  logic [9:0]  enum_div;
  logic [9:0]  run_div;
  logic [12:0] query_lim;
  logic [7:0]  ready_lim;

  sdioe_pkg::phase_t phase, phase_next;
  logic [12:0] attempts_left, attempts_left_next;
  logic [31:0] saved_ocr, saved_ocr_next;
  logic [15:0] saved_rca, saved_rca_next;

  sdioe_pkg::err_t err;
  logic [12:0]     query_first;
  logic [12:0]     ready_first;
  logic [31:0]     window_arg;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enum_div  <= sdioe_pkg::ENUM_DIV_RST;
      run_div   <= sdioe_pkg::RUN_DIV_RST;
      query_lim <= sdioe_pkg::QUERY_LIM_RST;
      ready_lim <= sdioe_pkg::READY_LIM_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sdioe_pkg::CFG_ENUM_DIV:  enum_div  <= cfg_data[9:0];
        sdioe_pkg::CFG_RUN_DIV:   run_div   <= cfg_data[9:0];
        sdioe_pkg::CFG_QUERY_LIM: query_lim <= cfg_data;
        sdioe_pkg::CFG_READY_LIM: ready_lim <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdioe_pkg::PH_IDLE;
      attempts_left <= '0;
      saved_ocr     <= '0;
      saved_rca     <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      attempts_left <= attempts_left_next;
      saved_ocr     <= saved_ocr_next;
      saved_rca     <= saved_rca_next;
    end
  end

  // Helpers: outcome class, first retry counts (limit zero means one try)
  assign err         = sdioe_pkg::outcome(item.error_flags, item.wait_expired);
  assign query_first = (query_lim == 13'd0) ? 13'd0 : query_lim - 13'd1;
  assign ready_first = (ready_lim == 8'd0) ? 13'd0 : {5'd0, ready_lim - 8'd1};
  assign window_arg  = saved_ocr & sdioe_pkg::VOLT_WINDOW;

  // Next state and result
  always_comb begin
    phase_next         = phase;
    attempts_left_next = attempts_left;
    saved_ocr_next     = saved_ocr;
    saved_rca_next     = saved_rca;
    res                = '0;
    res.action         = sdioe_pkg::ACT_WAIT;
    res.error_code     = sdioe_pkg::ERR_OK;

    if (item.op == sdioe_pkg::OP_START) begin
      res.action         = sdioe_pkg::ACT_CLOCK;
      res.clock_divisor  = enum_div;
      attempts_left_next = '0;
      phase_next         = sdioe_pkg::PH_CLK_ENUM;
    end else if (item.op == sdioe_pkg::OP_CLK_DONE &&
                 (phase == sdioe_pkg::PH_CLK_ENUM || phase == sdioe_pkg::PH_CLK_RUN)) begin
      if (err != sdioe_pkg::ERR_OK) begin
        res.action     = sdioe_pkg::ACT_FAIL;
        res.error_code = err;
        phase_next     = sdioe_pkg::PH_FAILED;
      end else if (phase == sdioe_pkg::PH_CLK_ENUM) begin
        res.action        = sdioe_pkg::ACT_ISSUE;
        res.cmd_index     = sdioe_pkg::CMD_GO_IDLE;
        res.response_kind = sdioe_pkg::RSP_NONE;
        phase_next        = sdioe_pkg::PH_CMD0;
      end else begin
        res.action = sdioe_pkg::ACT_OK;
        phase_next = sdioe_pkg::PH_DONE;
      end
    end else if (item.op == sdioe_pkg::OP_CMD_DONE) begin
      unique case (phase)
        // CMD0 outcome is ignored
        sdioe_pkg::PH_CMD0: begin
          attempts_left_next = query_first;
          res.action         = sdioe_pkg::ACT_ISSUE;
          res.cmd_index      = sdioe_pkg::CMD_IO_SEND;
          res.response_kind  = sdioe_pkg::RSP_SHORT;
          phase_next         = sdioe_pkg::PH_QUERY;
        end
        // OCR query, retried on timeout
        sdioe_pkg::PH_QUERY: begin
          if (err == sdioe_pkg::ERR_OK) begin
            saved_ocr_next     = item.response_word;
            attempts_left_next = ready_first;
            res.action         = sdioe_pkg::ACT_ISSUE;
            res.cmd_index      = sdioe_pkg::CMD_IO_SEND;
            res.cmd_argument   = item.response_word & sdioe_pkg::VOLT_WINDOW;
            res.response_kind  = sdioe_pkg::RSP_SHORT;
            phase_next         = sdioe_pkg::PH_READY;
          end else if (err == sdioe_pkg::ERR_TIMEOUT && attempts_left != 13'd0) begin
            attempts_left_next = attempts_left - 13'd1;
            res.action         = sdioe_pkg::ACT_ISSUE;
            res.cmd_index      = sdioe_pkg::CMD_IO_SEND;
            res.response_kind  = sdioe_pkg::RSP_SHORT;
          end else begin
            res.action     = sdioe_pkg::ACT_FAIL;
            res.error_code = err;
            phase_next     = sdioe_pkg::PH_FAILED;
          end
        end
        // Wait for IORDY
        sdioe_pkg::PH_READY: begin
          if (err != sdioe_pkg::ERR_OK) begin
            res.action     = sdioe_pkg::ACT_FAIL;
            res.error_code = err;
            phase_next     = sdioe_pkg::PH_FAILED;
          end else if (item.response_word[sdioe_pkg::IORDY_POS]) begin
            res.action        = sdioe_pkg::ACT_ISSUE;
            res.cmd_index     = sdioe_pkg::CMD_SEND_RCA;
            res.response_kind = sdioe_pkg::RSP_SHORT;
            res.check_enable  = 1'b1;
            phase_next        = sdioe_pkg::PH_CMD3;
          end else if (attempts_left != 13'd0) begin
            attempts_left_next = attempts_left - 13'd1;
            res.action         = sdioe_pkg::ACT_ISSUE;
            res.cmd_index      = sdioe_pkg::CMD_IO_SEND;
            res.cmd_argument   = window_arg;
            res.response_kind  = sdioe_pkg::RSP_SHORT;
          end else begin
            res.action     = sdioe_pkg::ACT_FAIL;
            res.error_code = sdioe_pkg::ERR_ENUM;
            phase_next     = sdioe_pkg::PH_FAILED;
          end
        end
        // RCA capture, then select
        sdioe_pkg::PH_CMD3: begin
          if (err != sdioe_pkg::ERR_OK) begin
            res.action     = sdioe_pkg::ACT_FAIL;
            res.error_code = err;
            phase_next     = sdioe_pkg::PH_FAILED;
          end else begin
            saved_rca_next    = item.response_word[31:16];
            res.action        = sdioe_pkg::ACT_ISSUE;
            res.cmd_index     = sdioe_pkg::CMD_SELECT;
            res.cmd_argument  = {item.response_word[31:16], 16'd0};
            res.response_kind = sdioe_pkg::RSP_BUSY;
            res.check_enable  = 1'b1;
            phase_next        = sdioe_pkg::PH_CMD7;
          end
        end
        // Card selected: request full-speed clock
        sdioe_pkg::PH_CMD7: begin
          if (err != sdioe_pkg::ERR_OK) begin
            res.action     = sdioe_pkg::ACT_FAIL;
            res.error_code = err;
            phase_next     = sdioe_pkg::PH_FAILED;
          end else begin
            res.action        = sdioe_pkg::ACT_CLOCK;
            res.clock_divisor = run_div;
            phase_next        = sdioe_pkg::PH_CLK_RUN;
          end
        end
        default: ;
      endcase
    end

    res.card_ocr     = saved_ocr_next;
    res.card_address = saved_rca_next;
  end

endmodule

// ===== hdl/sdioe_out_reg.sv =====
// Result register: holds a result beat until the consumer takes it.
`timescale 1ns / 1ps

module sdioe_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               out_stall,
  input  sdioe_pkg::result_t res_d,
  output sdioe_pkg::result_t res_q,
  output logic               out_valid,
  output logic               can_load
);

  // Free when empty or when the held beat leaves this cycle
  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== hdl/sdio_card_enumeration_sequencer.sv =====
// An accepted beat goes from the input register through the step logic into the result register.
// Throughput: one event per cycle; the input register, the step logic and the
// result register form a two-stage pipe that only holds while out_stall is high.
// Reset (rst, synchronous): phase idle, counters and saved OCR/RCA cleared,
// config registers back to defaults, both stages empty.
// Top level of the SDIO card enumeration sequencer.
`timescale 1ns / 1ps

module sdio_card_enumeration_sequencer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // event input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [6:0]  error_flags,
  input  logic        wait_expired,
  input  logic [31:0] response_word,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [5:0]  cmd_index,
  output logic [31:0] cmd_argument,
  output logic [1:0]  response_kind,
  output logic        check_enable,
  output logic [9:0]  clock_divisor,
  output logic [2:0]  error_code,
  output logic [31:0] card_ocr,
  output logic [15:0] card_address
);

  sdioe_pkg::item_t   item_d, item_q;
  sdioe_pkg::result_t res_d, res_q;
  logic               item_valid;
  logic               can_load;
  logic               accept;
  logic               fire;

  // Handshake
  assign fire     = item_valid && can_load;
  assign in_stall = item_valid && !can_load;
  assign accept   = in_valid && !in_stall;

  assign item_d.op            = op;
  assign item_d.error_flags   = error_flags;
  assign item_d.wait_expired  = wait_expired;
  assign item_d.response_word = response_word;

  sdioe_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .advance    (can_load),
    .item_d     (item_d),
    .item_q     (item_q),
    .item_valid (item_valid)
  );

  sdioe_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item_q),
    .res       (res_d)
  );

  sdioe_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .out_stall (out_stall),
    .res_d     (res_d),
    .res_q     (res_q),
    .out_valid (out_valid),
    .can_load  (can_load)
  );

  // Result fields
  assign action        = res_q.action;
  assign cmd_index     = res_q.cmd_index;
  assign cmd_argument  = res_q.cmd_argument;
  assign response_kind = res_q.response_kind;
  assign check_enable  = res_q.check_enable;
  assign clock_divisor = res_q.clock_divisor;
  assign error_code    = res_q.error_code;
  assign card_ocr      = res_q.card_ocr;
  assign card_address  = res_q.card_address;

`ifndef ASSERT_OFF
  // Error code is nonzero exactly on a failed beat
  a_err_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((action == sdioe_pkg::ACT_FAIL) == (error_code != sdioe_pkg::ERR_OK)))
    else $error("error_code does not match failed action");

  // Command fields only on issue beats, divisor only on clock beats
  a_fields_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action != sdioe_pkg::ACT_ISSUE) |->
      (cmd_index == 6'd0 && cmd_argument == 32'd0 && !check_enable &&
       (action == sdioe_pkg::ACT_CLOCK || clock_divisor == 10'd0)))
    else $error("stray payload on non-issue beat");

  // The input stage only stalls while it is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("input stalled while empty");

  // Every beat that fires from the input stage is loaded into the result register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("step fired without a result beat");
`endif

endmodule
